// ===== rtl/rtu_pkg.sv =====
package rtu_pkg;

	localparam logic [1:0] MODE_HYPOT    = 2'd0;
	localparam logic [1:0] MODE_CHECK    = 2'd1;
	localparam logic [1:0] MODE_LEG      = 2'd2;
	localparam logic [1:0] MODE_CLASSIFY = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SHORT    = 2'd1;
	localparam logic [1:0] STATUS_LEG_LONG = 2'd2;

	localparam logic [1:0] CLASS_RIGHT  = 2'd0;
	localparam logic [1:0] CLASS_ACUTE  = 2'd1;
	localparam logic [1:0] CLASS_OBTUSE = 2'd2;

	// 1.0 in q.8
	localparam int MIN_LENGTH_RESET = 256;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] status;
		logic [1:0] tri_class;
	} rtu_ctrl_t;

endpackage

// ===== rtl/right_triangle_unit.sv =====
// the pipeline from an accepted input word to its result word has one squaring stage,
// one add/compare stage and one square-root stage per result bit
// throughput: one word per cycle while the output is not stalled; each stage loads whenever
// it is empty or the stage after it moves, so bubbles close up while the output is stalled
// reset clears all stage valid bits and sets min_length to 1.0
module right_triangle_unit #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// min_length
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [LENGTH_BITS-1:0]                cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// first_leg, second_leg, hypotenuse
	input  logic [((3*LENGTH_BITS+7)/8)*8-1:0]    s_axis_tdata,
	// mode
	input  logic [1:0]                            s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// triangle_class, root_value, square_sum, hyp_square
	output logic [((5*LENGTH_BITS+4+7)/8)*8-1:0]  m_axis_tdata,
	// status
	output logic [1:0]                            m_axis_tuser
);
	import rtu_pkg::*;

	localparam int ROOT_BITS  = LENGTH_BITS + 1;
	localparam int SUM_W      = 2 * LENGTH_BITS + 1;
	localparam int SQ_W       = 2 * LENGTH_BITS;
	localparam int RAD_W      = 2 * ROOT_BITS;
	localparam int REM_W      = ROOT_BITS + 2;
	localparam int STAGES     = ROOT_BITS + 2;
	localparam int OUT_DATA_W = ((5*LENGTH_BITS+4+7)/8)*8;

	logic [LENGTH_BITS-1:0] min_length_q;

	logic [STAGES-1:0] stage_en;
	logic [STAGES-1:0] stage_valid;

	rtu_ctrl_t          ctrl_s1;
	logic [SQ_W-1:0]    asq_s1, bsq_s1, csq_s1;
	rtu_ctrl_t          ctrl_s2;
	logic [SUM_W-1:0]   sum_s2, rad_s2;
	logic [SQ_W-1:0]    hsq_s2;

	// index 0 feeds the first root step, index ROOT_BITS is the output register
	rtu_ctrl_t              ctrl_p [ROOT_BITS+1];
	logic [SUM_W-1:0]       sum_p  [ROOT_BITS+1];
	logic [SQ_W-1:0]        hsq_p  [ROOT_BITS+1];
	logic [RAD_W-1:0]       rad_p  [ROOT_BITS+1];
	logic [REM_W-1:0]       rem_p  [ROOT_BITS+1];
	logic [ROOT_BITS-1:0]   root_p [ROOT_BITS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= LENGTH_BITS'(MIN_LENGTH_RESET);
		end else if (cfg_valid) begin
			min_length_q <= cfg_data;
		end
	end

	// a stage moves when it is empty or its successor moves
	always_comb begin
		stage_en[STAGES-1] = !stage_valid[STAGES-1] | m_axis_tready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			stage_en[k] = !stage_valid[k] | stage_en[k+1];
		end
	end

	assign s_axis_tready = stage_en[0];

	rtu_prep #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (stage_en[0]),
		.in_valid   (s_axis_tvalid),
		.mode       (s_axis_tuser),
		.first_leg  (s_axis_tdata[LENGTH_BITS-1:0]),
		.second_leg (s_axis_tdata[2*LENGTH_BITS-1:LENGTH_BITS]),
		.hypotenuse (s_axis_tdata[3*LENGTH_BITS-1:2*LENGTH_BITS]),
		.min_length (min_length_q),
		.valid_s1   (stage_valid[0]),
		.ctrl_s1    (ctrl_s1),
		.asq_s1     (asq_s1),
		.bsq_s1     (bsq_s1),
		.csq_s1     (csq_s1)
	);

	rtu_combine #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (stage_en[1]),
		.in_valid (stage_valid[0]),
		.ctrl     (ctrl_s1),
		.asq      (asq_s1),
		.bsq      (bsq_s1),
		.csq      (csq_s1),
		.valid_s2 (stage_valid[1]),
		.ctrl_s2  (ctrl_s2),
		.sum_s2   (sum_s2),
		.hsq_s2   (hsq_s2),
		.rad_s2   (rad_s2)
	);

	assign ctrl_p[0] = ctrl_s2;
	assign sum_p[0]  = sum_s2;
	assign hsq_p[0]  = hsq_s2;
	assign rad_p[0]  = RAD_W'(rad_s2);
	assign rem_p[0]  = '0;
	assign root_p[0] = '0;

	for (genvar i = 0; i < ROOT_BITS; i++) begin : g_root
		rtu_root_step #(
			.ROOT_BITS(ROOT_BITS)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (stage_en[i+2]),
			.in_valid (stage_valid[i+1]),
			.ctrl     (ctrl_p[i]),
			.sum      (sum_p[i]),
			.hsq      (hsq_p[i]),
			.rad      (rad_p[i]),
			.rem      (rem_p[i]),
			.root     (root_p[i]),
			.valid_sn (stage_valid[i+2]),
			.ctrl_sn  (ctrl_p[i+1]),
			.sum_sn   (sum_p[i+1]),
			.hsq_sn   (hsq_p[i+1]),
			.rad_sn   (rad_p[i+1]),
			.rem_sn   (rem_p[i+1]),
			.root_sn  (root_p[i+1])
		);
	end

	assign m_axis_tvalid = stage_valid[STAGES-1];
	assign m_axis_tuser  = ctrl_p[ROOT_BITS].status;
	assign m_axis_tdata  = OUT_DATA_W'({hsq_p[ROOT_BITS], sum_p[ROOT_BITS],
		root_p[ROOT_BITS], ctrl_p[ROOT_BITS].tri_class});

`ifndef SYNTHESIS
	// a rejected request carries no numbers
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STATUS_OK) |->
		(root_p[ROOT_BITS] == '0) && (sum_p[ROOT_BITS] == '0) &&
		(hsq_p[ROOT_BITS] == '0) && (ctrl_p[ROOT_BITS].tri_class == CLASS_RIGHT))
		else $error("rejected result with nonzero payload");

	// the root never overshoots its radicand
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(RAD_W'(root_p[ROOT_BITS]) * RAD_W'(root_p[ROOT_BITS]) <=
		RAD_W'(sum_p[ROOT_BITS])))
		else $error("square root larger than radicand");

	// input backpressure only comes from a full pipe behind a stalled output
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (&stage_valid) && !m_axis_tready)
		else $error("input stalled with room in the pipeline");

	// a result leaving the pipe means a word entered it earlier
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(stage_valid[STAGES-2]))
		else $error("result appeared without a predecessor stage");
`endif

endmodule

// ===== rtl/rtu_prep.sv =====
module rtu_prep #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [1:0]                 mode,
	input  logic [LENGTH_BITS-1:0]     first_leg,
	input  logic [LENGTH_BITS-1:0]     second_leg,
	input  logic [LENGTH_BITS-1:0]     hypotenuse,
	input  logic [LENGTH_BITS-1:0]     min_length,
	output logic                       valid_s1,
	output rtu_pkg::rtu_ctrl_t         ctrl_s1,
	output logic [2*LENGTH_BITS-1:0]   asq_s1,
	output logic [2*LENGTH_BITS-1:0]   bsq_s1,
	output logic [2*LENGTH_BITS-1:0]   csq_s1
);
	import rtu_pkg::*;

	localparam int SQ_W = 2 * LENGTH_BITS;

	logic       a_short, b_short, c_short;
	logic       low, exceed;
	rtu_ctrl_t  ctrl;

	assign a_short = first_leg < min_length;
	assign b_short = second_leg < min_length;
	assign c_short = hypotenuse < min_length;

	always_comb begin
		unique case (mode)
			MODE_HYPOT: low = a_short | b_short;
			MODE_LEG:   low = a_short | c_short;
			default:    low = a_short | b_short | c_short;
		endcase
		exceed = ((mode == MODE_LEG) && (first_leg > hypotenuse)) ||
			((mode == MODE_CLASSIFY) &&
			((first_leg > hypotenuse) || (second_leg > hypotenuse)));
		ctrl.mode      = mode;
		ctrl.tri_class = CLASS_RIGHT;
		// the minimum check wins over the leg check
		if (low) begin
			ctrl.status = STATUS_SHORT;
		end else if (exceed) begin
			ctrl.status = STATUS_LEG_LONG;
		end else begin
			ctrl.status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= ctrl;
			asq_s1  <= SQ_W'(first_leg) * SQ_W'(first_leg);
			bsq_s1  <= SQ_W'(second_leg) * SQ_W'(second_leg);
			csq_s1  <= SQ_W'(hypotenuse) * SQ_W'(hypotenuse);
		end
	end

endmodule

// ===== rtl/rtu_combine.sv =====
module rtu_combine #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  rtu_pkg::rtu_ctrl_t         ctrl,
	input  logic [2*LENGTH_BITS-1:0]   asq,
	input  logic [2*LENGTH_BITS-1:0]   bsq,
	input  logic [2*LENGTH_BITS-1:0]   csq,
	output logic                       valid_s2,
	output rtu_pkg::rtu_ctrl_t         ctrl_s2,
	output logic [2*LENGTH_BITS:0]     sum_s2,
	output logic [2*LENGTH_BITS-1:0]   hsq_s2,
	output logic [2*LENGTH_BITS:0]     rad_s2
);
	import rtu_pkg::*;

	localparam int SUM_W = 2 * LENGTH_BITS + 1;
	localparam int SQ_W  = 2 * LENGTH_BITS;

	logic [SUM_W-1:0] leg_sum, leg_diff, sum, rad;
	logic [SQ_W-1:0]  hsq;
	rtu_ctrl_t        ctrl_n;

	assign leg_sum  = SUM_W'(asq) + SUM_W'(bsq);
	assign leg_diff = SUM_W'(csq) - SUM_W'(asq);

	always_comb begin
		ctrl_n = ctrl;
		sum    = '0;
		hsq    = '0;
		rad    = '0;
		if (ctrl.status == STATUS_OK) begin
			unique case (ctrl.mode) inside
				MODE_HYPOT: begin
					sum = leg_sum;
					rad = leg_sum;
				end
				MODE_LEG: begin
					sum = leg_diff;
					hsq = csq;
					rad = leg_diff;
				end
				MODE_CHECK, MODE_CLASSIFY: begin
					sum = leg_sum;
					hsq = csq;
					if (leg_sum == SUM_W'(csq)) begin
						ctrl_n.tri_class = CLASS_RIGHT;
					end else if (leg_sum > SUM_W'(csq)) begin
						ctrl_n.tri_class = CLASS_ACUTE;
					end else begin
						ctrl_n.tri_class = CLASS_OBTUSE;
					end
				end
				default: begin
					sum = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s2 <= ctrl_n;
			sum_s2  <= sum;
			hsq_s2  <= hsq;
			rad_s2  <= rad;
		end
	end

endmodule

// ===== rtl/rtu_root_step.sv =====
module rtu_root_step #(
	parameter int ROOT_BITS = 25
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  rtu_pkg::rtu_ctrl_t         ctrl,
	input  logic [2*ROOT_BITS-2:0]     sum,
	input  logic [2*ROOT_BITS-3:0]     hsq,
	input  logic [2*ROOT_BITS-1:0]     rad,
	input  logic [ROOT_BITS+1:0]       rem,
	input  logic [ROOT_BITS-1:0]       root,
	output logic                       valid_sn,
	output rtu_pkg::rtu_ctrl_t         ctrl_sn,
	output logic [2*ROOT_BITS-2:0]     sum_sn,
	output logic [2*ROOT_BITS-3:0]     hsq_sn,
	output logic [2*ROOT_BITS-1:0]     rad_sn,
	output logic [ROOT_BITS+1:0]       rem_sn,
	output logic [ROOT_BITS-1:0]       root_sn
);
	import rtu_pkg::*;

	localparam int REM_W = ROOT_BITS + 2;
	localparam int RAD_W = 2 * ROOT_BITS;

	logic [REM_W+1:0] partial, trial;
	logic             take;

	// bring down the next two radicand bits and try root*4+1
	assign partial = {rem, rad[RAD_W-1 -: 2]};
	assign trial   = (REM_W+2)'({root, 2'b01});
	assign take    = partial >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_sn <= ctrl;
			sum_sn  <= sum;
			hsq_sn  <= hsq;
			rad_sn  <= {rad[RAD_W-3:0], 2'b00};
			rem_sn  <= take ? REM_W'(partial - trial) : REM_W'(partial);
			root_sn <= {root[ROOT_BITS-2:0], take};
		end
	end

endmodule

// ===== tb/tb_right_triangle_unit.sv =====
module tb_right_triangle_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import rtu_pkg::*;

	localparam int LEN_W      = 24;
	localparam int IN_W       = ((3*LEN_W+7)/8)*8;
	localparam int OUT_W      = ((5*LEN_W+4+7)/8)*8;
	localparam int LATENCY    = LEN_W + 3;
	localparam int PHASE_LEN  = 147;
	localparam int NUM_PHASES = 7;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  tri_class;
		logic [24:0] root;
		logic [48:0] sum;
		logic [47:0] hyp_sq;
	} triangle_result_t;

	typedef struct {
		logic [1:0]       mode;
		logic [LEN_W-1:0] leg_a;
		logic [LEN_W-1:0] leg_b;
		logic [LEN_W-1:0] hyp;
		bit               known;
		triangle_result_t result;
	} request_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic [1:0]       s_axis_tuser;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [1:0]       m_axis_tuser;

	triangle_result_t pending_results[$];
	request_row_t     directed_rows[$];
	triangle_result_t expected_word;
	logic [LEN_W-1:0] min_length_shadow;
	bit               gaps_enabled;
	bit               stalls_enabled;
	int               error_count;
	int               requests_sent;
	int               status_seen[3];
	int               class_seen[3];

	right_triangle_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// digit-by-digit floor square root
	function automatic logic [24:0] floor_root(logic [48:0] n);
		logic [63:0] r;
		logic [63:0] trial;
		r = '0;
		for (int i = 24; i >= 0; i--) begin
			trial = r | (64'd1 << i);
			if (trial * trial <= 64'(n))
				r = trial;
		end
		return r[24:0];
	endfunction

	function automatic triangle_result_t solve_triangle(logic [1:0] mode, logic [LEN_W-1:0] a,
		logic [LEN_W-1:0] b, logic [LEN_W-1:0] c, logic [LEN_W-1:0] lim);
		triangle_result_t res;
		logic [48:0]      a_sq;
		logic [48:0]      b_sq;
		logic [48:0]      c_sq;
		bit               short_len;
		res = '0;
		a_sq = 49'(a) * 49'(a);
		b_sq = 49'(b) * 49'(b);
		c_sq = 49'(c) * 49'(c);
		case (mode)
			MODE_HYPOT: short_len = (a < lim) || (b < lim);
			MODE_LEG:   short_len = (a < lim) || (c < lim);
			default:    short_len = (a < lim) || (b < lim) || (c < lim);
		endcase
		if (short_len) begin
			res.status = STATUS_SHORT;
		end else if ((mode == MODE_LEG && a > c) || (mode == MODE_CLASSIFY && (a > c || b > c))) begin
			res.status = STATUS_LEG_LONG;
		end else begin
			res.status = STATUS_OK;
			case (mode)
				MODE_HYPOT: begin
					res.sum = a_sq + b_sq;
					res.root = floor_root(res.sum);
				end
				MODE_LEG: begin
					res.hyp_sq = c_sq[47:0];
					res.sum = c_sq - a_sq;
					res.root = floor_root(res.sum);
				end
				default: begin
					res.hyp_sq = c_sq[47:0];
					res.sum = a_sq + b_sq;
					if (res.sum == c_sq)
						res.tri_class = CLASS_RIGHT;
					else if (res.sum > c_sq)
						res.tri_class = CLASS_ACUTE;
					else
						res.tri_class = CLASS_OBTUSE;
				end
			endcase
		end
		return res;
	endfunction

	function automatic logic [LEN_W-1:0] pick_length(logic [LEN_W-1:0] lo);
		logic [LEN_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = lo;
			1: v = LEN_MAX;
			2: v = (lo > LEN_MAX - 24'd4096) ? lo : lo + LEN_W'($urandom_range(0, 4095));
			default: v = LEN_W'($urandom_range(32'(LEN_MAX), 32'(lo)));
		endcase
		return v;
	endfunction

	function automatic logic [LEN_W-1:0] pick_leg(logic [LEN_W-1:0] lo, logic [LEN_W-1:0] c);
		logic [LEN_W-1:0] v;
		if (c < lo)
			v = c;
		else begin
			case ($urandom_range(0, 7))
				0: v = c;
				1: v = lo;
				default: v = LEN_W'($urandom_range(32'(c), 32'(lo)));
			endcase
		end
		return v;
	endfunction

	task automatic add_row(logic [1:0] mode, logic [LEN_W-1:0] a, logic [LEN_W-1:0] b,
		logic [LEN_W-1:0] c, bit known, logic [1:0] status, logic [1:0] cls,
		logic [24:0] root, logic [48:0] sum, logic [47:0] hyp_sq);
		request_row_t row;
		row.mode = mode;
		row.leg_a = a;
		row.leg_b = b;
		row.hyp = c;
		row.known = known;
		row.result.status = status;
		row.result.tri_class = cls;
		row.result.root = root;
		row.result.sum = sum;
		row.result.hyp_sq = hyp_sq;
		directed_rows.push_back(row);
	endtask

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_request(logic [1:0] mode, logic [LEN_W-1:0] a, logic [LEN_W-1:0] b,
		logic [LEN_W-1:0] c, bit known, triangle_result_t typed);
		if (gaps_enabled && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {c, b, a};
		do @(posedge clk); while (!s_axis_tready);
		if (known)
			pending_results.push_back(typed);
		else
			pending_results.push_back(solve_triangle(mode, a, b, c, min_length_shadow));
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_request();
		logic [1:0]       mode;
		logic [LEN_W-1:0] a;
		logic [LEN_W-1:0] b;
		logic [LEN_W-1:0] c;
		logic [LEN_W-1:0] t;
		int unsigned      p;
		int unsigned      q;
		int unsigned      h;
		int unsigned      k;
		int unsigned      kmax;
		int               kind;
		mode = 2'($urandom_range(0, 3));
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			// noise
			a = LEN_W'($urandom);
			b = LEN_W'($urandom);
			c = LEN_W'($urandom);
		end else if (kind <= 2) begin
			// scaled integer right triangles
			case ($urandom_range(0, 3))
				0: begin p = 3; q = 4;  h = 5;  end
				1: begin p = 5; q = 12; h = 13; end
				2: begin p = 8; q = 15; h = 17; end
				default: begin p = 7; q = 24; h = 25; end
			endcase
			kmax = 32'(LEN_MAX) / h;
			k = $urandom_range(0, 1) ? $urandom_range(kmax, 1)
				: $urandom_range((kmax < 2000) ? kmax : 2000, 1);
			a = LEN_W'(p * k);
			b = LEN_W'(q * k);
			c = LEN_W'(h * k);
			if ($urandom_range(0, 1)) begin
				t = a;
				a = b;
				b = t;
			end
		end else begin
			c = pick_length(min_length_shadow);
			if (mode == MODE_HYPOT) begin
				a = pick_length(min_length_shadow);
				b = pick_length(min_length_shadow);
			end else begin
				a = pick_leg(min_length_shadow, c);
				b = pick_leg(min_length_shadow, c);
			end
			// now and then a leg longer than the hypotenuse
			if ($urandom_range(0, 9) == 0 && c != LEN_MAX)
				a = LEN_W'($urandom_range(32'(LEN_MAX), 32'(c) + 1));
		end
		send_request(mode, a, b, c, 1'b0, '0);
	endtask

	task automatic write_min_length(logic [LEN_W-1:0] value);
		while (pending_results.size() != 0)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		min_length_shadow = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic note_mismatch(string field, logic [63:0] exp_val, logic [63:0] act_val);
		error_count++;
		if (error_count <= 10)
			$display("mismatch %s: expected %0d got %0d (request %0d pending %0d)",
				field, exp_val, act_val, requests_sent, pending_results.size());
	endtask

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result word: status %0d data %h", m_axis_tuser, m_axis_tdata);
			end else begin
				expected_word = pending_results.pop_front();
				if (m_axis_tuser != expected_word.status)
					note_mismatch("status", 64'(expected_word.status), 64'(m_axis_tuser));
				if (m_axis_tdata[1:0] != expected_word.tri_class)
					note_mismatch("triangle_class", 64'(expected_word.tri_class), 64'(m_axis_tdata[1:0]));
				if (m_axis_tdata[26:2] != expected_word.root)
					note_mismatch("root_value", 64'(expected_word.root), 64'(m_axis_tdata[26:2]));
				if (m_axis_tdata[75:27] != expected_word.sum)
					note_mismatch("square_sum", 64'(expected_word.sum), 64'(m_axis_tdata[75:27]));
				if (m_axis_tdata[123:76] != expected_word.hyp_sq)
					note_mismatch("hyp_square", 64'(expected_word.hyp_sq), 64'(m_axis_tdata[123:76]));
				if (m_axis_tuser < 3)
					status_seen[m_axis_tuser]++;
				if (m_axis_tuser == STATUS_OK && m_axis_tdata[1:0] < 3 &&
					(m_axis_tdata[26:2] == 0) && (m_axis_tdata[123:76] != 0))
					class_seen[m_axis_tdata[1:0]]++;
			end
		end
	end

	// output backpressure
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (stalls_enabled && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [LEN_W-1:0] phase_min[NUM_PHASES];
		request_row_t     row;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_HYPOT;
		gaps_enabled = 1'b1;
		stalls_enabled = 1'b1;
		error_count = 0;
		requests_sent = 0;
		min_length_shadow = LEN_W'(MIN_LENGTH_RESET);

		phase_min[0] = '0;
		phase_min[1] = LEN_MAX;
		phase_min[2] = 24'd1;
		phase_min[3] = LEN_W'($urandom);
		phase_min[4] = 24'h800000;
		phase_min[5] = LEN_W'($urandom_range(0, 24'h2000));
		phase_min[6] = LEN_W'(MIN_LENGTH_RESET);

		// 3-4-5 in q.8: 768, 1024, 1280
		add_row(MODE_HYPOT, 24'd768, 24'd1024, 24'd0, 1'b1, STATUS_OK, CLASS_RIGHT,
			25'd1280, 49'd1638400, 48'd0);
		add_row(MODE_CHECK, 24'd768, 24'd1024, 24'd1280, 1'b1, STATUS_OK, CLASS_RIGHT,
			25'd0, 49'd1638400, 48'd1638400);
		// second leg is don't-care in leg mode, even below the minimum
		add_row(MODE_LEG, 24'd768, 24'd0, 24'd1280, 1'b1, STATUS_OK, CLASS_RIGHT,
			25'd1024, 49'd1048576, 48'd1638400);
		add_row(MODE_CLASSIFY, 24'd768, 24'd1024, 24'd1280, 1'b1, STATUS_OK, CLASS_RIGHT,
			25'd0, 49'd1638400, 48'd1638400);
		add_row(MODE_CLASSIFY, 24'd768, 24'd768, 24'd1280, 1'b0, '0, '0, '0, '0, '0);
		add_row(MODE_CLASSIFY, 24'd1024, 24'd1024, 24'd1280, 1'b0, '0, '0, '0, '0, '0);
		add_row(MODE_HYPOT, LEN_MAX, LEN_MAX, 24'd0, 1'b0, '0, '0, '0, '0, '0);
		add_row(MODE_LEG, LEN_MAX, 24'd123, LEN_MAX, 1'b1, STATUS_OK, CLASS_RIGHT,
			25'd0, 49'd0, 48'd281474943156225);
		add_row(MODE_CHECK, LEN_MAX, LEN_MAX, LEN_MAX, 1'b0, '0, '0, '0, '0, '0);
		add_row(MODE_CLASSIFY, LEN_MAX, LEN_MAX, LEN_MAX, 1'b0, '0, '0, '0, '0, '0);
		add_row(MODE_HYPOT, 24'd255, 24'd1024, 24'd5000, 1'b1, STATUS_SHORT, '0, '0, '0, '0);
		add_row(MODE_CHECK, 24'd768, 24'd1024, 24'd255, 1'b1, STATUS_SHORT, '0, '0, '0, '0);
		add_row(MODE_LEG, 24'd768, 24'd1024, 24'd0, 1'b1, STATUS_SHORT, '0, '0, '0, '0);
		add_row(MODE_CLASSIFY, 24'd768, 24'd0, 24'd1280, 1'b1, STATUS_SHORT, '0, '0, '0, '0);
		add_row(MODE_LEG, 24'd1281, 24'd0, 24'd1280, 1'b1, STATUS_LEG_LONG, '0, '0, '0, '0);
		add_row(MODE_CLASSIFY, 24'd512, 24'd1281, 24'd1280, 1'b1, STATUS_LEG_LONG,
			'0, '0, '0, '0);
		add_row(MODE_CLASSIFY, 24'd1281, 24'd512, 24'd1280, 1'b1, STATUS_LEG_LONG,
			'0, '0, '0, '0);
		// short length wins over a long leg
		add_row(MODE_CLASSIFY, 24'd1281, 24'd100, 24'd1280, 1'b1, STATUS_SHORT,
			'0, '0, '0, '0);
		// right check ignores leg against hypotenuse
		add_row(MODE_CHECK, 24'd2000, 24'd2000, 24'd256, 1'b0, '0, '0, '0, '0, '0);
		add_row(MODE_HYPOT, 24'd256, 24'd256, 24'd0, 1'b0, '0, '0, '0, '0, '0);
		add_row(MODE_LEG, 24'd256, 24'd0, 24'd256, 1'b0, '0, '0, '0, '0, '0);
		add_row(MODE_CLASSIFY, 24'h555555, 24'hAAAAAA, LEN_MAX, 1'b0, '0, '0, '0, '0, '0);
		add_row(MODE_HYPOT, 24'hAAAAAA, 24'h555555, 24'h555555, 1'b0, '0, '0, '0, '0, '0);
		add_row(MODE_LEG, 24'h555555, 24'hAAAAAA, 24'hAAAAAA, 1'b0, '0, '0, '0, '0, '0);

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_request(row.mode, row.leg_a, row.leg_b, row.hyp, row.known, row.result);
		end
		s_axis_tvalid <= 1'b0;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_min_length(phase_min[ph]);
			if (ph == NUM_PHASES - 1) begin
				gaps_enabled = 1'b0;
				stalls_enabled = 1'b0;
			end
			for (int n = 0; n < PHASE_LEN; n++)
				send_random_request();
			s_axis_tvalid <= 1'b0;
		end

		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);

		$display("%0d requests under %0d min_length settings; ok/short/leg-long %0d/%0d/%0d",
			requests_sent, NUM_PHASES + 1, status_seen[0], status_seen[1], status_seen[2]);
		$display("classified right/acute/obtuse %0d/%0d/%0d, %0d mismatches",
			class_seen[0], class_seen[1], class_seen[2], error_count);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== right_triangle_unit.f =====
rtl/rtu_pkg.sv
rtl/rtu_prep.sv
rtl/rtu_combine.sv
rtl/rtu_root_step.sv
rtl/right_triangle_unit.sv
tb/tb_right_triangle_unit.sv
